// ===== src/cfe_pkg.sv =====
// Shared constants and types for the CRC-8 framed byte encoder.
package cfe_pkg;

   localparam logic [7:0] SYNC_FIRST   = 8'h55;
   localparam logic [7:0] SYNC_SECOND  = 8'hAA;
   localparam logic [7:0] CRC_INIT     = 8'hFF;
   localparam logic [7:0] CRC_POLY     = 8'h31;
   localparam logic [7:0] CRC_TOP      = 8'h80;
   localparam logic [7:0] LENGTH_RESET = 8'd14;

   // Everything one accepted item sends out: optional header, data, optional crc
   typedef struct packed {
      logic       with_header;
      logic [7:0] length_byte;
      logic [7:0] data_byte;
      logic       with_crc;
      logic [7:0] crc_byte;
   } burst_type;

endpackage

// ===== src/cfe_crc_fold.sv =====
// Folds one byte into a CRC-8 (poly 0x31, MSB first, not reflected).
module cfe_crc_fold (
   input  logic [7:0] crc_cur,
   input  logic [7:0] data_byte,
   output logic [7:0] crc_next
);

   // Shift the byte through the polynomial, one bit per step
   always_comb begin
      logic [7:0] v;
      v = crc_cur ^ data_byte;
      for (int i = 0; i < 8; i++) begin
         if ((v & cfe_pkg::CRC_TOP) != 8'h00) begin
            v = (v << 1) ^ cfe_pkg::CRC_POLY;
         end else begin
            v = v << 1;
         end
      end
      crc_next = v;
   end

endmodule

// ===== src/cfe_out_seq.sv =====
// Output register that walks the bytes of one item's burst onto the result channel.
module cfe_out_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  cfe_pkg::burst_type  load_burst,
   output logic                load_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_last_of_run,
   output logic                rsp_end_of_frame
);

   typedef enum logic [2:0] {
      SLOT_SYNC1,
      SLOT_SYNC2,
      SLOT_LEN,
      SLOT_DATA,
      SLOT_CRC
   } slot_type;

   logic               valid_ff, valid_in;
   slot_type           slot_ff, slot_in;
   cfe_pkg::burst_type burst_ff, burst_in;
   slot_type           slot_step;
   slot_type           slot_first;
   logic               is_last;
   logic               take;
   logic               load;

   // Pick the byte for the current slot
   always_comb begin
      unique case (slot_ff)
         SLOT_SYNC1: rsp_frame_byte = cfe_pkg::SYNC_FIRST;
         SLOT_SYNC2: rsp_frame_byte = cfe_pkg::SYNC_SECOND;
         SLOT_LEN:   rsp_frame_byte = burst_ff.length_byte;
         SLOT_DATA:  rsp_frame_byte = burst_ff.data_byte;
         SLOT_CRC:   rsp_frame_byte = burst_ff.crc_byte;
         default:    rsp_frame_byte = burst_ff.data_byte;
      endcase
   end

   // Advance through the slots
   always_comb begin
      unique case (slot_ff)
         SLOT_SYNC1: slot_step = SLOT_SYNC2;
         SLOT_SYNC2: slot_step = SLOT_LEN;
         SLOT_LEN:   slot_step = SLOT_DATA;
         SLOT_DATA:  slot_step = SLOT_CRC;
         SLOT_CRC:   slot_step = SLOT_CRC;
         default:    slot_step = SLOT_CRC;
      endcase
   end

   assign is_last          = (slot_ff == SLOT_CRC) ||
                             ((slot_ff == SLOT_DATA) && !burst_ff.with_crc);
   assign rsp_valid        = valid_ff;
   assign rsp_last_of_run  = is_last;
   assign rsp_end_of_frame = (slot_ff == SLOT_CRC);
   assign take             = valid_ff && rsp_ready;
   assign load_ready       = !valid_ff || (take && is_last);
   assign load             = load_valid && load_ready;
   assign slot_first       = load_burst.with_header ? SLOT_SYNC1 : SLOT_DATA;

   // Load a new burst, step on each taken byte, drop after the last
   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      burst_in = burst_ff;
      if (load) begin
         valid_in = 1'b1;
         slot_in  = slot_first;
         burst_in = load_burst;
      end else if (take) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            slot_in = slot_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= SLOT_DATA;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
      burst_ff <= burst_in;
   end

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_end_of_frame |-> rsp_last_of_run)
      else $error("crc byte not marked as last of run");

   a_header_start: assert property (@(posedge clock) disable iff (reset)
      load && load_burst.with_header |=> valid_ff && (slot_ff == SLOT_SYNC1))
      else $error("burst with header did not start at first sync byte");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      take && is_last && !load_valid |=> !valid_ff)
      else $error("output stayed valid after last byte of run");

   a_crc_only_if_flagged: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (slot_ff == SLOT_CRC) |-> burst_ff.with_crc)
      else $error("crc slot reached without crc");

endmodule

// ===== src/crc8_frame_encoder_top.sv =====
// Top level of the CRC-8 framed byte encoder: frame state, length register, output.
// The first result of an item is registered and shown in the cycle after the item is accepted.
// One item per cycle for a mid-frame byte while rsp_ready is high; the single output register
// sends one byte per cycle and sends a frame's first byte as sync, sync, length, data, its last
// byte as data, crc and the byte of a one-byte frame as sync, sync, length, data, crc.
// Reset: position 0, crc 0xFF, payload length 14, output register empty.
module crc8_frame_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_payload_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_end_of_frame,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_payload_length
);

   logic [7:0]         length_ff, length_in;
   logic [7:0]         position_ff, position_in;
   logic [7:0]         crc_ff, crc_in;
   logic [7:0]         crc_folded;
   logic [8:0]         next_count;
   logic               frame_done;
   logic               accept;
   cfe_pkg::burst_type burst;

   assign csr_ready = 1'b1;

   cfe_crc_fold u_crc_fold (
      .crc_cur   (crc_ff),
      .data_byte (req_payload_byte),
      .crc_next  (crc_folded)
   );

   // Frame ends when the count reaches the length; a length of zero means 256
   assign next_count = {1'b0, position_ff} + 9'd1;
   assign frame_done = (length_ff == 8'd0) ? next_count[8]
                                           : (next_count >= {1'b0, length_ff});
   assign accept     = req_valid && req_ready;

   // Build the burst for this item
   always_comb begin
      burst.with_header = (position_ff == 8'd0);
      burst.length_byte = length_ff;
      burst.data_byte   = req_payload_byte;
      burst.with_crc    = frame_done;
      burst.crc_byte    = crc_folded;
   end

   // Advance frame state on each accepted item, restart after the crc
   always_comb begin
      length_in   = (csr_valid && csr_ready) ? csr_payload_length : length_ff;
      position_in = position_ff;
      crc_in      = crc_ff;
      if (accept) begin
         if (frame_done) begin
            position_in = 8'd0;
            crc_in      = cfe_pkg::CRC_INIT;
         end else begin
            position_in = next_count[7:0];
            crc_in      = crc_folded;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= cfe_pkg::LENGTH_RESET;
         position_ff <= 8'd0;
         crc_ff      <= cfe_pkg::CRC_INIT;
      end else begin
         length_ff   <= length_in;
         position_ff <= position_in;
         crc_ff      <= crc_in;
      end
   end

   cfe_out_seq u_out_seq (
      .clock            (clock),
      .reset            (reset),
      .load_valid       (req_valid),
      .load_burst       (burst),
      .load_ready       (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && frame_done |=> (position_ff == 8'd0) && (crc_ff == cfe_pkg::CRC_INIT))
      else $error("frame state did not restart after crc");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(position_ff) && $stable(crc_ff))
      else $error("frame state moved without an accepted item");

   a_crc_fresh: assert property (@(posedge clock) disable iff (reset)
      position_ff == 8'd0 |-> crc_ff == cfe_pkg::CRC_INIT)
      else $error("crc not at initial value at start of frame");

endmodule
